// ===== hw/rtl/epvs_pkg.sv =====
// Package for the EPROM program/verify sequencer: field widths, opcodes,
// result kinds, register indexes, the result record and its builder.
// No dependencies.
`default_nettype none

package epvs_pkg;

   localparam int unsigned MAX_DEVICE_BYTES_DEF = 8192;

   localparam int unsigned OFFSET_W    = 14;
   localparam int unsigned ADDR_W      = 13;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned SUM_W       = 32;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 14;
   localparam int unsigned RQ_DEPTH    = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_KIND    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_SIZE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RETRY_LIMIT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_VERIFY_ENABLED = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_EXTRA_PULSES   = 3'd4;

   localparam logic [1:0] DEV_2708    = 2'd0;
   localparam logic [1:0] DEV_2716    = 2'd1;
   localparam logic [1:0] DEV_MCM6876 = 2'd2;

   localparam int unsigned PIN20_ADDR_BIT = 10;

   typedef enum logic [1:0] {
      OP_START    = 2'd0,
      OP_PROGRAM  = 2'd1,
      OP_READBACK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      K_PULSE     = 3'd0,
      K_DONE      = 3'd1,
      K_COMPLETE  = 3'd2,
      K_EXHAUSTED = 3'd3,
      K_REJECTED  = 3'd4,
      K_STARTED   = 3'd5
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0]          device_kind;
      logic [OFFSET_W-1:0] device_size;
      logic [COUNT_W-1:0]  retry_limit;
      logic                verify_enabled;
      logic [COUNT_W-1:0]  extra_pulses;
   } cfg_type;

   typedef struct packed {
      rsp_kind_type        kind;
      logic [ADDR_W-1:0]   prog_address;
      logic [BYTE_W-1:0]   prog_data;
      logic                pulse_long;
      logic                vpp_rest_zero;
      logic                pin20_low;
      logic                await_readback;
      logic [COUNT_W-1:0]  report_max_pulses;
      logic [SUM_W-1:0]    report_total_pulses;
      logic                last_result;
   } rsp_type;

   // Build one result record from the state seen at the time it is issued.
   function automatic rsp_type make_rsp(
      input rsp_kind_type        kind,
      input logic [OFFSET_W-1:0] offset,
      input logic [BYTE_W-1:0]   held,
      input logic                waiting,
      input logic [COUNT_W-1:0]  worst,
      input logic [SUM_W-1:0]    total,
      input logic [1:0]          dev_kind
   );
      rsp_type r;
      logic    has_byte;
      has_byte = (kind == K_PULSE) || (kind == K_DONE) ||
                 (kind == K_COMPLETE) || (kind == K_EXHAUSTED);
      r = '0;
      r.kind           = kind;
      r.prog_address   = has_byte ? offset[ADDR_W-1:0] : '0;
      r.prog_data      = has_byte ? held : '0;
      r.await_readback = waiting;
      if (kind == K_PULSE) begin
         r.pulse_long    = (dev_kind == DEV_MCM6876);
         r.vpp_rest_zero = (dev_kind != DEV_MCM6876);
         r.pin20_low     = (dev_kind == DEV_2716) && !offset[PIN20_ADDR_BIT];
      end
      if (kind == K_COMPLETE) begin
         r.report_max_pulses   = worst;
         r.report_total_pulses = (dev_kind == DEV_MCM6876) ? total : '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epvs_core.sv =====
// Sequencer state and per-request decision logic: one request in, one or
// two result records out, all decided combinationally. Depends on epvs_pkg.
`default_nettype none

module epvs_core
   import epvs_pkg::*;
#(
   parameter int unsigned MAX_DEVICE_BYTES = MAX_DEVICE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [1:0]        op,
   input  wire logic [BYTE_W-1:0] value,
   input  wire cfg_type           cfg,
   output rsp_type                rsp0,
   output rsp_type                rsp1,
   output logic                   two
);

   localparam logic [31:0] MAX_BYTES = 32'(MAX_DEVICE_BYTES);

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                waiting_ff, waiting_in;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  limit_ff, limit_in;
   logic                verified_ff, verified_in;
   logic [COUNT_W-1:0]  worst_ff, worst_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic [OFFSET_W-1:0] after;
   logic                past_end;
   logic [COUNT_W-1:0]  prog_limit;
   logic [COUNT_W:0]    ext_sum;
   logic [COUNT_W-1:0]  ext_limit;
   logic                match;
   logic                rb_verified;
   logic [COUNT_W-1:0]  rb_limit;
   logic [COUNT_W-1:0]  fin_count;
   logic [COUNT_W-1:0]  fin_worst;
   logic [SUM_W-1:0]    fin_sum;
   rsp_kind_type        fin_kind;

   assign after      = offset_ff + 1'b1;
   assign past_end   = (offset_ff >= cfg.device_size) ||
                       ({{(32-OFFSET_W){1'b0}}, offset_ff} >= MAX_BYTES);
   assign prog_limit = cfg.verify_enabled ? cfg.retry_limit : COUNT_W'(1);
   assign ext_sum    = {1'b0, count_ff} + {1'b0, cfg.extra_pulses};
   assign ext_limit  = ext_sum[COUNT_W] ? '1 : ext_sum[COUNT_W-1:0];
   assign match      = (value == held_ff) && !verified_ff;
   assign rb_verified = verified_ff || match;
   assign rb_limit   = match ? ext_limit : limit_ff;

   // Statistics for a finished byte; the program path finishes at one pulse.
   assign fin_count = (op == OP_PROGRAM) ? COUNT_W'(1) : count_ff;
   assign fin_worst = (fin_count > worst_ff) ? fin_count : worst_ff;
   assign fin_sum   = sum_ff + {{(SUM_W-COUNT_W){1'b0}}, fin_count};
   assign fin_kind  = (after == cfg.device_size) ? K_COMPLETE : K_DONE;

   always_comb begin
      offset_in   = offset_ff;
      waiting_in  = waiting_ff;
      held_in     = held_ff;
      count_in    = count_ff;
      limit_in    = limit_ff;
      verified_in = verified_ff;
      worst_in    = worst_ff;
      sum_in      = sum_ff;
      two         = 1'b0;
      rsp0 = make_rsp(K_REJECTED, offset_ff, held_ff, waiting_ff, worst_ff, sum_ff,
                      cfg.device_kind);
      rsp1 = rsp0;
      unique case (op)
         OP_START: begin
            offset_in   = '0;
            waiting_in  = 1'b0;
            held_in     = '0;
            count_in    = '0;
            limit_in    = '0;
            verified_in = 1'b0;
            worst_in    = '0;
            sum_in      = '0;
            rsp0 = make_rsp(K_STARTED, '0, '0, 1'b0, '0, '0, cfg.device_kind);
         end
         OP_PROGRAM: begin
            if (!waiting_ff && !past_end) begin
               held_in     = value;
               verified_in = 1'b0;
               count_in    = '0;
               limit_in    = prog_limit;
               if (prog_limit == '0) begin
                  rsp0 = make_rsp(K_EXHAUSTED, offset_ff, value, waiting_ff, worst_ff,
                                  sum_ff, cfg.device_kind);
               end else if (cfg.verify_enabled) begin
                  count_in   = COUNT_W'(1);
                  waiting_in = 1'b1;
                  rsp0 = make_rsp(K_PULSE, offset_ff, value, 1'b1, worst_ff, sum_ff,
                                  cfg.device_kind);
               end else begin
                  // Single pulse completes the byte: pulse then done/complete.
                  count_in    = COUNT_W'(1);
                  verified_in = 1'b1;
                  worst_in    = fin_worst;
                  sum_in      = fin_sum;
                  offset_in   = after;
                  two         = 1'b1;
                  rsp0 = make_rsp(K_PULSE, offset_ff, value, waiting_ff, worst_ff,
                                  sum_ff, cfg.device_kind);
                  rsp1 = make_rsp(fin_kind, offset_ff, value, waiting_ff, fin_worst,
                                  fin_sum, cfg.device_kind);
               end
            end
         end
         OP_READBACK: begin
            if (waiting_ff) begin
               verified_in = rb_verified;
               limit_in    = rb_limit;
               if (count_ff < rb_limit) begin
                  count_in = count_ff + 1'b1;
                  rsp0 = make_rsp(K_PULSE, offset_ff, held_ff, 1'b1, worst_ff, sum_ff,
                                  cfg.device_kind);
               end else begin
                  waiting_in = 1'b0;
                  if (rb_verified) begin
                     worst_in  = fin_worst;
                     sum_in    = fin_sum;
                     offset_in = after;
                     rsp0 = make_rsp(fin_kind, offset_ff, held_ff, 1'b0, fin_worst,
                                     fin_sum, cfg.device_kind);
                  end else begin
                     rsp0 = make_rsp(K_EXHAUSTED, offset_ff, held_ff, 1'b0, worst_ff,
                                     sum_ff, cfg.device_kind);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rsp0.last_result = !two;
      rsp1.last_result = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         waiting_ff  <= 1'b0;
         held_ff     <= '0;
         count_ff    <= '0;
         limit_ff    <= '0;
         verified_ff <= 1'b0;
         worst_ff    <= '0;
         sum_ff      <= '0;
      end else if (take) begin
         offset_ff   <= offset_in;
         waiting_ff  <= waiting_in;
         held_ff     <= held_in;
         count_ff    <= count_in;
         limit_ff    <= limit_in;
         verified_ff <= verified_in;
         worst_ff    <= worst_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/epvs_rsp_queue.sv =====
// Result queue: takes one or two records per cycle, hands out one
// while out_ready is high. Depends on epvs_pkg.
`default_nettype none

module epvs_rsp_queue
   import epvs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire logic    push_two,
   input  wire rsp_type wr0,
   input  wire rsp_type wr1,
   output logic         room,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_rsp
);

   localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
   localparam int unsigned CNT_W = $clog2(RQ_DEPTH + 1);

   rsp_type            slot_ff [RQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;
   logic [CNT_W-1:0]   n_push;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_rsp   = slot_ff[rd_ptr_ff];
   // Room for the worst case of two records from one request.
   assign room      = (count_ff <= CNT_W'(RQ_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;
   assign n_push    = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + n_push - (pop ? CNT_W'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr0;
         if (push_two) begin
            slot_ff[wr_next] <= wr1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/eprom_program_verify_sequencer_unit.sv =====
// Top level of the EPROM program/verify sequencer: configuration registers,
// decision core and result queue. Depends on epvs_pkg, epvs_core, epvs_rsp_queue.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   req     | in        | req_valid/req_ready  | req_op, req_value
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_result_kind ... rsp_last_result
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A request is decided in the cycle it is accepted; its results land in a
// four-entry queue and show on rsp_* once they reach its head. One request per
// cycle is taken while the queue has room for two results, so the rate is one
// request per cycle, limited by the single-read output port of the queue and by
// rsp_ready (a program request with verify off yields two results, which leave
// the queue one at a time). Reset clears the sequencer state, the queue and
// all registers. A stalled rsp side holds the queue head; req_ready drops once
// fewer than two entries are free.
`default_nettype none

module eprom_program_verify_sequencer_unit
   import epvs_pkg::*;
#(
   parameter int unsigned MAX_DEVICE_BYTES = MAX_DEVICE_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_op,
   input  wire logic [BYTE_W-1:0]      req_value,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_result_kind,
   output logic [ADDR_W-1:0]           rsp_prog_address,
   output logic [BYTE_W-1:0]           rsp_prog_data,
   output logic                        rsp_pulse_long,
   output logic                        rsp_vpp_rest_zero,
   output logic                        rsp_pin20_low,
   output logic                        rsp_await_readback,
   output logic [COUNT_W-1:0]          rsp_report_max_pulses,
   output logic [SUM_W-1:0]            rsp_report_total_pulses,
   output logic                        rsp_last_result,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    take;
   logic    room;
   logic    two;
   rsp_type rsp0, rsp1, head;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DEVICE_KIND:    cfg_in.device_kind    = csr_data[1:0];
            REG_DEVICE_SIZE:    cfg_in.device_size    = csr_data[OFFSET_W-1:0];
            REG_RETRY_LIMIT:    cfg_in.retry_limit    = csr_data[COUNT_W-1:0];
            REG_VERIFY_ENABLED: cfg_in.verify_enabled = csr_data[0];
            REG_EXTRA_PULSES:   cfg_in.extra_pulses   = csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a request whenever the queue can absorb two results.
   assign req_ready = room;
   assign take      = req_valid && req_ready;

   epvs_core #(
      .MAX_DEVICE_BYTES(MAX_DEVICE_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .op    (req_op),
      .value (req_value),
      .cfg   (cfg_ff),
      .rsp0  (rsp0),
      .rsp1  (rsp1),
      .two   (two)
   );

   epvs_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_two  (two),
      .wr0       (rsp0),
      .wr1       (rsp1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (head)
   );

   assign rsp_result_kind         = head.kind;
   assign rsp_prog_address        = head.prog_address;
   assign rsp_prog_data           = head.prog_data;
   assign rsp_pulse_long          = head.pulse_long;
   assign rsp_vpp_rest_zero       = head.vpp_rest_zero;
   assign rsp_pin20_low           = head.pin20_low;
   assign rsp_await_readback      = head.await_readback;
   assign rsp_report_max_pulses   = head.report_max_pulses;
   assign rsp_report_total_pulses = head.report_total_pulses;
   assign rsp_last_result         = head.last_result;

endmodule

`default_nettype wire

// ===== bench/eprom_program_verify_sequencer_unit_test.sv =====
// Self-checking bench for the EPROM program/verify sequencer: predicts every result,
// drives random requests and register writes, stalls both channels at random.
// Depends on epvs_pkg and eprom_program_verify_sequencer_unit.
module eprom_program_verify_sequencer_unit_test;
   import epvs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TARGET_REQUESTS = 550;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned DRAIN_CYCLES    = 6;
   localparam int unsigned HOLD_CYCLES     = 80;

   // The block has no name for the fourth opcode or the upper register slots.
   localparam logic [1:0]             OP_UNDEFINED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED   = 3'd7;

   // Predictor of the sequencer: its own copy of the registers and session
   // state, and the results each accepted request should produce, oldest first.
   class sequencer_scoreboard;
      logic [1:0]          dev_kind;
      logic [OFFSET_W-1:0] part_bytes;
      logic [COUNT_W-1:0]  retry_lim;
      logic                verify_on;
      logic [COUNT_W-1:0]  extra;

      logic [OFFSET_W-1:0] offset;
      logic                waiting;
      logic [BYTE_W-1:0]   held;
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  limit;
      logic                verified;
      logic [COUNT_W-1:0]  worst;
      logic [SUM_W-1:0]    sum;

      rsp_type results_due[$];
      int      errors;
      int      kind_tally[8];

      function new();
         dev_kind = '0; part_bytes = '0; retry_lim = '0; verify_on = 1'b0; extra = '0;
         clear_session();
         errors = 0;
         foreach (kind_tally[i]) kind_tally[i] = 0;
      endfunction

      function void clear_session();
         offset = '0; waiting = 1'b0; held = '0; count = '0; limit = '0;
         verified = 1'b0; worst = '0; sum = '0;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_DEVICE_KIND:    dev_kind   = data[1:0];
            REG_DEVICE_SIZE:    part_bytes = data[OFFSET_W-1:0];
            REG_RETRY_LIMIT:    retry_lim  = data[COUNT_W-1:0];
            REG_VERIFY_ENABLED: verify_on  = data[0];
            REG_EXTRA_PULSES:   extra      = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Fields follow the registers and state at the moment the result is issued.
      function void emit_result(rsp_kind_type k, logic [OFFSET_W-1:0] addr);
         rsp_type r;
         r = '0;
         r.kind = k;
         if (k == K_PULSE || k == K_DONE || k == K_COMPLETE || k == K_EXHAUSTED) begin
            r.prog_address = addr[ADDR_W-1:0];
            r.prog_data    = held;
         end
         if (k == K_PULSE) begin
            r.pulse_long    = (dev_kind == DEV_MCM6876);
            r.vpp_rest_zero = (dev_kind != DEV_MCM6876);
            r.pin20_low     = (dev_kind == DEV_2716) && !addr[PIN20_ADDR_BIT];
         end
         r.await_readback = waiting;
         if (k == K_COMPLETE) begin
            r.report_max_pulses   = worst;
            r.report_total_pulses = (dev_kind == DEV_MCM6876) ? sum : '0;
         end
         results_due.push_back(r);
      endfunction

      // Verified byte: fold its pulses into the statistics and advance the offset.
      function void close_byte();
         logic [OFFSET_W-1:0] after;
         after = offset + 1'b1;
         if (count > worst) worst = count;
         sum = sum + count;
         emit_result((after == part_bytes) ? K_COMPLETE : K_DONE, offset);
         offset = after;
      endfunction

      function void take_request(logic [1:0] op, logic [BYTE_W-1:0] val);
         rsp_type     tail;
         logic [COUNT_W:0] lim;
         case (op)
            OP_START: begin
               clear_session();
               emit_result(K_STARTED, '0);
            end
            OP_PROGRAM: begin
               if (waiting || offset >= part_bytes || offset >= MAX_DEVICE_BYTES_DEF) begin
                  emit_result(K_REJECTED, '0);
               end else begin
                  held     = val;
                  verified = 1'b0;
                  count    = '0;
                  limit    = verify_on ? retry_lim : 8'd1;
                  if (limit == 0) begin
                     emit_result(K_EXHAUSTED, offset);
                  end else begin
                     count = 8'd1;
                     if (verify_on) begin
                        waiting = 1'b1;
                        emit_result(K_PULSE, offset);
                     end else begin
                        emit_result(K_PULSE, offset);
                        verified = 1'b1;
                        close_byte();
                     end
                  end
               end
            end
            OP_READBACK: begin
               if (!waiting) begin
                  emit_result(K_REJECTED, '0);
               end else begin
                  // First match fixes the limit: pulses so far plus the extras, capped.
                  if (val == held && !verified) begin
                     lim      = count + extra;
                     verified = 1'b1;
                     limit    = (lim > 255) ? 8'd255 : lim[COUNT_W-1:0];
                  end
                  if (count < limit) begin
                     count = count + 1'b1;
                     emit_result(K_PULSE, offset);
                  end else begin
                     waiting = 1'b0;
                     if (verified) close_byte();
                     else emit_result(K_EXHAUSTED, offset);
                  end
               end
            end
            default: emit_result(K_REJECTED, '0);
         endcase
         tail = results_due.pop_back();
         tail.last_result = 1'b1;
         results_due.push_back(tail);
      endfunction

      function void check_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (results_due.size() == 0) begin
            $error("result_kind %0d arrived with no result outstanding", got.kind);
            errors++;
            return;
         end
         want = results_due.pop_front();
         kind_tally[want.kind]++;
         check_field("result_kind", want.kind, got.kind);
         check_field("prog_address", want.prog_address, got.prog_address);
         check_field("prog_data", want.prog_data, got.prog_data);
         check_field("pulse_long", want.pulse_long, got.pulse_long);
         check_field("vpp_rest_zero", want.vpp_rest_zero, got.vpp_rest_zero);
         check_field("pin20_low", want.pin20_low, got.pin20_low);
         check_field("await_readback", want.await_readback, got.await_readback);
         check_field("report_max_pulses", want.report_max_pulses, got.report_max_pulses);
         check_field("report_total_pulses", want.report_total_pulses,
                     got.report_total_pulses);
         check_field("last_result", want.last_result, got.last_result);
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op    = '0;
   logic [BYTE_W-1:0]      req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [2:0]             rsp_result_kind;
   logic [ADDR_W-1:0]      rsp_prog_address;
   logic [BYTE_W-1:0]      rsp_prog_data;
   logic                   rsp_pulse_long;
   logic                   rsp_vpp_rest_zero;
   logic                   rsp_pin20_low;
   logic                   rsp_await_readback;
   logic [COUNT_W-1:0]     rsp_report_max_pulses;
   logic [SUM_W-1:0]       rsp_report_total_pulses;
   logic                   rsp_last_result;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   sequencer_scoreboard sb = new();

   int      send_idle_pct  = 36;   // chance of a gap before each request
   int      stall_pct      = 82;   // chance the result side holds ready low
   int      requests_sent  = 0;
   int      config_phases  = 0;
   int      burst_requests = 0;    // bumped by the stimulus to ask for a long hold-off
   int      burst_served   = 0;
   int      hold_left      = 0;
   int      cycles         = 0;
   rsp_type observed;

   eprom_program_verify_sequencer_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_op                  (req_op),
      .req_value               (req_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_result_kind         (rsp_result_kind),
      .rsp_prog_address        (rsp_prog_address),
      .rsp_prog_data           (rsp_prog_data),
      .rsp_pulse_long          (rsp_pulse_long),
      .rsp_vpp_rest_zero       (rsp_vpp_rest_zero),
      .rsp_pin20_low           (rsp_pin20_low),
      .rsp_await_readback      (rsp_await_readback),
      .rsp_report_max_pulses   (rsp_report_max_pulses),
      .rsp_report_total_pulses (rsp_report_total_pulses),
      .rsp_last_result         (rsp_last_result),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run once the cycle budget is used up.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: sample the handshake as it stood before this edge, check the
   // request's result, then pick ready for the next cycle. A long hold-off,
   // when asked for, is counted down here and overrides the random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.kind                = rsp_kind_type'(rsp_result_kind);
         observed.prog_address        = rsp_prog_address;
         observed.prog_data           = rsp_prog_data;
         observed.pulse_long          = rsp_pulse_long;
         observed.vpp_rest_zero       = rsp_vpp_rest_zero;
         observed.pin20_low           = rsp_pin20_low;
         observed.await_readback      = rsp_await_readback;
         observed.report_max_pulses   = rsp_report_max_pulses;
         observed.report_total_pulses = rsp_report_total_pulses;
         observed.last_result         = rsp_last_result;
         sb.check_result(observed);
      end
      if (burst_served != burst_requests) begin
         burst_served = burst_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request and hold it until taken. Valid stays high on return so
   // back-to-back requests follow without a gap; anything that waits drops it.
   task automatic send_request(input logic [1:0] op, input logic [BYTE_W-1:0] value);
      // Swap the idle pattern by thirds: slow receiver, then slow sender, then none.
      if (requests_sent < TARGET_REQUESTS / 3) begin
         send_idle_pct = 36; stall_pct = 82;
      end else if (requests_sent < 2 * TARGET_REQUESTS / 3) begin
         send_idle_pct = 82; stall_pct = 36;
      end else begin
         send_idle_pct = 0; stall_pct = 0;
         // Once the sender runs flat out, starve the result side so the queue
         // fills and the block has to push back on requests.
         if (burst_requests == 0) burst_requests++;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      sb.take_request(op, value);
      requests_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back, then let
   // the block drain so it is truly idle before its registers change.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(index, data);
   endtask

   task automatic write_config(input logic [1:0] kind, input logic [OFFSET_W-1:0] size,
                               input logic [COUNT_W-1:0] retry, input logic verify,
                               input logic [COUNT_W-1:0] extra);
      settle();
      csr_write(REG_DEVICE_KIND, CSR_DATA_W'(kind));
      csr_write(REG_DEVICE_SIZE, size);
      csr_write(REG_RETRY_LIMIT, CSR_DATA_W'(retry));
      csr_write(REG_VERIFY_ENABLED, CSR_DATA_W'(verify));
      csr_write(REG_EXTRA_PULSES, CSR_DATA_W'(extra));
      csr_valid <= 1'b0;
      config_phases++;
   endtask

   // Program one byte and answer every pulse with a readback until the byte
   // closes; readbacks match the held byte at the given rate, with a little
   // noise (a program while waiting, or a start that abandons the byte).
   task automatic program_byte(input int match_pct);
      int roll;
      send_request(OP_PROGRAM, BYTE_W'($urandom));
      while (sb.waiting) begin
         roll = $urandom_range(99);
         if (roll < 3) send_request(OP_PROGRAM, BYTE_W'($urandom));
         else if (roll < 5) send_request(OP_START, BYTE_W'($urandom));
         else if ($urandom_range(99) < match_pct) send_request(OP_READBACK, sb.held);
         else send_request(OP_READBACK, BYTE_W'($urandom));
      end
   endtask

   task automatic random_session();
      logic [1:0]          kind;
      logic [OFFSET_W-1:0] size;
      logic [COUNT_W-1:0]  retry;
      logic [COUNT_W-1:0]  extra;
      logic                verify;
      int                  n_bytes;
      int                  match_pct;
      int                  roll;
      kind   = 2'($urandom_range(3));
      roll   = $urandom_range(99);
      size   = (roll < 8) ? 14'd0 : (roll < 16) ? OFFSET_W'($urandom_range(8192, 16383))
                                                : OFFSET_W'($urandom_range(1, 10));
      roll   = $urandom_range(99);
      retry  = (roll < 75) ? COUNT_W'($urandom_range(0, 6))
                           : COUNT_W'($urandom_range(7, 40));
      extra  = ($urandom_range(99) < 85) ? COUNT_W'($urandom_range(0, 3))
                                         : COUNT_W'($urandom_range(4, 20));
      verify = ($urandom_range(99) < 70);
      match_pct = $urandom_range(10, 70);
      write_config(kind, size, retry, verify, extra);
      send_request(OP_START, BYTE_W'($urandom));
      n_bytes = ((size > 10) ? 10 : int'(size)) + $urandom_range(0, 2);
      for (int i = 0; i < n_bytes; i++) begin
         roll = $urandom_range(99);
         if (roll < 4) send_request(OP_UNDEFINED, BYTE_W'($urandom));
         else if (roll < 7) send_request(OP_READBACK, BYTE_W'($urandom));
         else if (roll < 9) send_request(OP_START, BYTE_W'($urandom));
         program_byte(match_pct);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: size zero, so programs are turned away.
      send_request(OP_PROGRAM, 8'h00);
      send_request(OP_READBACK, 8'hFF);        // nothing to read back
      send_request(OP_UNDEFINED, 8'h80);
      send_request(OP_START, 8'h00);

      // Verify off on a three-byte part: each program is one pulse and a done,
      // the last one completes the device, and one more runs past the end.
      settle();
      csr_write(REG_UNUSED, 14'h3FFF);         // unmapped slot: must change nothing
      write_config(DEV_MCM6876, 14'd3, 8'd0, 1'b0, 8'd0);
      send_request(OP_PROGRAM, 8'h00);
      send_request(OP_PROGRAM, 8'hFF);
      send_request(OP_PROGRAM, 8'hA5);
      send_request(OP_PROGRAM, 8'h3C);

      // Verify on with no retries: the byte gives up before any pulse.
      write_config(DEV_2716, 14'd16383, 8'd0, 1'b1, 8'd0);
      send_request(OP_START, 8'hFF);
      send_request(OP_PROGRAM, 8'h5A);

      // Three retries: match on the second pulse, then a byte that never
      // matches (a program while waiting is refused), then the same address
      // again, abandoned by a start.
      write_config(DEV_2716, 14'd16383, 8'd3, 1'b1, 8'd0);
      send_request(OP_PROGRAM, 8'h5A);
      send_request(OP_READBACK, 8'h00);
      send_request(OP_READBACK, 8'h5A);
      send_request(OP_PROGRAM, 8'h11);
      send_request(OP_PROGRAM, 8'h22);
      send_request(OP_READBACK, 8'hEE);
      send_request(OP_READBACK, 8'hEE);
      send_request(OP_READBACK, 8'hEE);
      send_request(OP_PROGRAM, 8'h11);
      send_request(OP_START, 8'h11);
      send_request(OP_READBACK, 8'h11);

      // Unlisted device kind behaves as the oldest part; two extra pulses.
      write_config(2'd3, 14'd8192, 8'd3, 1'b1, 8'd2);
      send_request(OP_PROGRAM, 8'h80);
      send_request(OP_READBACK, 8'h80);
      send_request(OP_READBACK, 8'h7F);
      send_request(OP_READBACK, 8'h01);

      // Largest limits: the first match plus 255 extras caps at 255 pulses,
      // and the one-byte device reports that worst case and total.
      write_config(DEV_MCM6876, 14'd1, 8'd255, 1'b1, 8'd255);
      send_request(OP_START, BYTE_W'($urandom));
      send_request(OP_PROGRAM, 8'hC3);
      send_request(OP_READBACK, 8'hC3);
      while (sb.waiting) send_request(OP_READBACK, BYTE_W'($urandom));

      while (requests_sent < TARGET_REQUESTS) random_session();

      settle();
      $display("Sent %0d requests under %0d register settings; checked %0d pulses,",
               requests_sent, config_phases, sb.kind_tally[K_PULSE]);
      $display("%0d bytes done, %0d completes, %0d exhausted, %0d rejected, %0d starts.",
               sb.kind_tally[K_DONE], sb.kind_tally[K_COMPLETE],
               sb.kind_tally[K_EXHAUSTED], sb.kind_tally[K_REJECTED],
               sb.kind_tally[K_STARTED]);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
